// File: rtl/core/sedh_pkg.sv
// ----------------------------------------------------------------------------
// sedh_pkg
// Shared types and constants for the substring hash compare core.
// ----------------------------------------------------------------------------
package sedh_pkg;

	localparam int FIELD_W    = 17;
	localparam int ADDR_W_MAX = 20;
	localparam int HASH_W     = 64;
	localparam int BASE_W     = 16;
	localparam int DIGIT_W    = 9;

	localparam logic [DIGIT_W-1:0] DIGIT_OFFSET = 9'd96;

	typedef enum logic {
		REG_BASE_ONE = 1'b0,
		REG_BASE_TWO = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		CMD_APPEND,
		CMD_COMPARE,
		CMD_REPLY
	} cmd_kind_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_A_MUL,
		BK_A_WR,
		BK_C_RB,
		BK_C_RA,
		BK_C_RD,
		BK_C_RC,
		BK_C_SUB,
		BK_M0,
		BK_M1,
		BK_M2,
		BK_C_OUT
	} back_state_t;

	typedef struct packed {
		logic                 req_type;
		logic                 start_new;
		logic [7:0]           char_byte;
		logic [FIELD_W-1:0]   first_start;
		logic [FIELD_W-1:0]   first_end;
		logic [FIELD_W-1:0]   second_start;
		logic [FIELD_W-1:0]   second_end;
	} item_t;

	typedef struct packed {
		logic similar;
		logic range_error;
	} result_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [7:0]            char_byte;
		logic [ADDR_W_MAX-1:0] idx_a;
		logic [ADDR_W_MAX-1:0] idx_b;
		logic [ADDR_W_MAX-1:0] idx_c;
		logic [ADDR_W_MAX-1:0] idx_d;
		logic [ADDR_W_MAX-1:0] diff;
		result_t               reply;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic full;
	} fifo_wr_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} fifo_rd_t;

endpackage

// File: rtl/core/sedh_front.sv
// ----------------------------------------------------------------------------
// sedh_front
// Accepts items, tracks loaded length, checks ranges and builds commands.
// ----------------------------------------------------------------------------
module sedh_front import sedh_pkg::*; #(
	parameter int MAX_LEN = 65536
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	input  logic  fifo_full,
	output logic  fifo_push,
	output cmd_t  cmd
);

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int XW = (LW > FIELD_W) ? LW : FIELD_W;

	logic [LW-1:0]         len_q;
	logic [LW-1:0]         eff_len;
	logic                  accept;
	logic                  is_full;
	logic [XW-1:0]         len_x, s1, e1, s2, e2;
	logic                  bad;
	logic [ADDR_W_MAX-1:0] a0, b0, c0, d0, a, b, c, d;

	assign item_stall = fifo_full;
	assign accept     = item_valid && !fifo_full;
	assign eff_len    = item.start_new ? '0 : len_q;
	assign is_full    = (eff_len == LW'(MAX_LEN));

	assign len_x = XW'(len_q);
	assign s1    = XW'(item.first_start);
	assign e1    = XW'(item.first_end);
	assign s2    = XW'(item.second_start);
	assign e2    = XW'(item.second_end);
	assign bad   = (s1 == '0) || (s1 > e1) || (e1 > len_x) ||
	               (s2 == '0) || (s2 > e2) || (e2 > len_x);

	always_comb begin
		a0 = ADDR_W_MAX'(item.first_start)  - 1'b1;
		b0 = ADDR_W_MAX'(item.first_end)    - 1'b1;
		c0 = ADDR_W_MAX'(item.second_start) - 1'b1;
		d0 = ADDR_W_MAX'(item.second_end)   - 1'b1;
		if (a0 > c0) begin
			a = c0; b = d0; c = a0; d = b0;
		end else begin
			a = a0; b = b0; c = c0; d = d0;
		end
		cmd           = '0;
		cmd.char_byte = item.char_byte;
		cmd.idx_a     = a;
		cmd.idx_b     = b;
		cmd.idx_c     = c;
		cmd.idx_d     = d;
		cmd.diff      = c - a;
		if (!item.req_type) begin
			cmd.kind  = CMD_APPEND;
			cmd.idx_a = ADDR_W_MAX'(eff_len);
		end else if (bad) begin
			cmd.kind              = CMD_REPLY;
			cmd.reply.range_error = 1'b1;
		end else if ((b - a) != (d - c)) begin
			cmd.kind = CMD_REPLY;
		end else begin
			cmd.kind = CMD_COMPARE;
		end
	end

	assign fifo_push = accept && (item.req_type || !is_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (accept && !item.req_type) begin
			len_q <= is_full ? eff_len : eff_len + 1'b1;
		end
	end

endmodule

// File: rtl/core/sedh_fifo.sv
// ----------------------------------------------------------------------------
// sedh_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module sedh_fifo import sedh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  cmd_t     wr_cmd,
	output fifo_wr_t wr_st,
	input  logic     pop,
	output cmd_t     rd_cmd,
	output fifo_rd_t rd_st
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign wr_st.push  = push;
	assign wr_st.full  = (count_q == 2'd2);
	assign rd_st.pop   = pop;
	assign rd_st.empty = (count_q == 2'd0);
	assign rd_cmd      = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: rtl/core/sedh_back.sv
// ----------------------------------------------------------------------------
// sedh_back
// Executes commands against the power and prefix-hash tables.
// ----------------------------------------------------------------------------
module sedh_back import sedh_pkg::*; #(
	parameter int MAX_LEN = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BASE_W-1:0] base_one,
	input  logic [BASE_W-1:0] base_two,
	input  cmd_t              cmd,
	input  logic              fifo_empty,
	output logic              fifo_pop,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result
);

	localparam int AW = $clog2(MAX_LEN);

	logic [HASH_W-1:0] pow1_mem [MAX_LEN];
	logic [HASH_W-1:0] pow2_mem [MAX_LEN];
	logic [HASH_W-1:0] pre1_mem [MAX_LEN];
	logic [HASH_W-1:0] pre2_mem [MAX_LEN];

	back_state_t state_q, state_d;
	cmd_t        cur_q;
	logic        out_free, out_load, mem_we;
	result_t     out_d;
	logic [AW-1:0] rd_pre_addr, rd_pow_addr;
	logic [HASH_W-1:0] rd_pre1_q, rd_pre2_q, rd_pow1_q, rd_pow2_q;
	logic [HASH_W-1:0] last_pow1_q, last_pow2_q, last_pre1_q, last_pre2_q;
	logic [HASH_W-1:0] pow1_s1, pow2_s1, new_pre1, new_pre2;
	logic [HASH_W-1:0] hx1_q, hx2_q, hy1_q, hy2_q, pw1_q, pw2_q, acc1_q, acc2_q;
	logic [DIGIT_W-1:0] digit;
	logic [31:0]       opa1, opb1, opa2, opb2;
	logic [HASH_W-1:0] prod1, prod2;
	logic              result_valid_q;
	result_t           result_q;

	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		fifo_pop    = 1'b0;
		out_load    = 1'b0;
		out_d       = '0;
		mem_we      = 1'b0;
		rd_pre_addr = cur_q.idx_b[AW-1:0];
		rd_pow_addr = cur_q.diff[AW-1:0];
		unique case (state_q)
			BK_IDLE: begin
				if (!fifo_empty) begin
					unique case (cmd.kind)
						CMD_APPEND: begin
							fifo_pop = 1'b1;
							state_d  = BK_A_MUL;
						end
						CMD_COMPARE: begin
							fifo_pop = 1'b1;
							state_d  = BK_C_RB;
						end
						default: begin
							if (out_free) begin
								fifo_pop = 1'b1;
								out_load = 1'b1;
								out_d    = cmd.reply;
							end
						end
					endcase
				end
			end
			BK_A_MUL: state_d = BK_A_WR;
			BK_A_WR: begin
				mem_we  = 1'b1;
				state_d = BK_IDLE;
			end
			BK_C_RB: state_d = BK_C_RA;
			BK_C_RA: begin
				rd_pre_addr = AW'(cur_q.idx_a - 1'b1);
				state_d     = BK_C_RD;
			end
			BK_C_RD: begin
				rd_pre_addr = cur_q.idx_d[AW-1:0];
				state_d     = BK_C_RC;
			end
			BK_C_RC: begin
				rd_pre_addr = AW'(cur_q.idx_c - 1'b1);
				state_d     = BK_C_SUB;
			end
			BK_C_SUB: state_d = BK_M0;
			BK_M0:    state_d = BK_M1;
			BK_M1:    state_d = BK_M2;
			BK_M2:    state_d = BK_C_OUT;
			BK_C_OUT: begin
				if (out_free) begin
					out_load      = 1'b1;
					out_d.similar = (acc1_q == hy1_q) && (acc2_q == hy2_q);
					state_d       = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// table ports
	always_ff @(posedge clk) begin
		rd_pre1_q <= pre1_mem[rd_pre_addr];
		rd_pre2_q <= pre2_mem[rd_pre_addr];
		rd_pow1_q <= pow1_mem[rd_pow_addr];
		rd_pow2_q <= pow2_mem[rd_pow_addr];
		if (mem_we) begin
			pow1_mem[cur_q.idx_a[AW-1:0]] <= pow1_s1;
			pow2_mem[cur_q.idx_a[AW-1:0]] <= pow2_s1;
			pre1_mem[cur_q.idx_a[AW-1:0]] <= new_pre1;
			pre2_mem[cur_q.idx_a[AW-1:0]] <= new_pre2;
		end
	end

	// append path: signed 9-bit digit as unsigned product minus 2^9 * power
	assign digit    = {1'b0, cur_q.char_byte} - DIGIT_OFFSET;
	assign new_pre1 = ((cur_q.idx_a == '0) ? '0 : last_pre1_q) + pow1_s1 * HASH_W'(digit)
	                  - (digit[DIGIT_W-1] ?
	                     {pow1_s1[HASH_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} : '0);
	assign new_pre2 = ((cur_q.idx_a == '0) ? '0 : last_pre2_q) + pow2_s1 * HASH_W'(digit)
	                  - (digit[DIGIT_W-1] ?
	                     {pow2_s1[HASH_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} : '0);

	// 64x64 mod 2^64 as three 32x32 steps
	always_comb begin
		opa1 = hx1_q[31:0];
		opa2 = hx2_q[31:0];
		opb1 = pw1_q[31:0];
		opb2 = pw2_q[31:0];
		if (state_q == BK_M1) begin
			opb1 = pw1_q[63:32];
			opb2 = pw2_q[63:32];
		end else if (state_q == BK_M2) begin
			opa1 = hx1_q[63:32];
			opa2 = hx2_q[63:32];
		end
	end
	assign prod1 = {32'b0, opa1} * {32'b0, opb1};
	assign prod2 = {32'b0, opa2} * {32'b0, opb2};

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (fifo_pop) cur_q <= cmd;
			end
			BK_A_MUL: begin
				pow1_s1 <= (cur_q.idx_a == '0) ? HASH_W'(1) : last_pow1_q * HASH_W'(base_one);
				pow2_s1 <= (cur_q.idx_a == '0) ? HASH_W'(1) : last_pow2_q * HASH_W'(base_two);
			end
			BK_A_WR: begin
				last_pow1_q <= pow1_s1;
				last_pow2_q <= pow2_s1;
				last_pre1_q <= new_pre1;
				last_pre2_q <= new_pre2;
			end
			BK_C_RA: begin
				hx1_q <= rd_pre1_q;
				hx2_q <= rd_pre2_q;
				pw1_q <= rd_pow1_q;
				pw2_q <= rd_pow2_q;
			end
			BK_C_RD: begin
				if (cur_q.idx_a != '0) begin
					hx1_q <= hx1_q - rd_pre1_q;
					hx2_q <= hx2_q - rd_pre2_q;
				end
			end
			BK_C_RC: begin
				hy1_q <= rd_pre1_q;
				hy2_q <= rd_pre2_q;
			end
			BK_C_SUB: begin
				if (cur_q.idx_c != '0) begin
					hy1_q <= hy1_q - rd_pre1_q;
					hy2_q <= hy2_q - rd_pre2_q;
				end
			end
			BK_M0: begin
				acc1_q <= prod1;
				acc2_q <= prod2;
			end
			BK_M1, BK_M2: begin
				acc1_q <= acc1_q + {prod1[31:0], 32'b0};
				acc2_q <= acc2_q + {prod2[31:0], 32'b0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) result_q <= out_d;
	end

endmodule

// File: rtl/core/substring_equality_by_double_hash_core.sv
// ----------------------------------------------------------------------------
// substring_equality_by_double_hash_core
// Substring equality test by double polynomial prefix hash, mod 2^64.
// ----------------------------------------------------------------------------
// In the back end, appends pass through the A_MUL and A_WR states. Compare items
// with valid, equal-length ranges make four reads through the single read
// port of each prefix table, then three 32x32 multiply steps per hash.
// Malformed or unequal-length compares need no table access. A two-entry
// queue lets the front accept items while the back end works. Tables are
// undefined after reset; no clearing pass is needed.
module substring_equality_by_double_hash_core import sedh_pkg::*; #(
	parameter int MAX_LEN = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [BASE_W-1:0]     cfg_data
);

	logic [BASE_W-1:0] base_one_q, base_two_q;
	logic              fifo_push, fifo_pop;
	cmd_t              wr_cmd, rd_cmd;
	fifo_wr_t          wr_st;
	fifo_rd_t          rd_st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_one_q <= 16'd4;
			base_two_q <= 16'd9;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_BASE_ONE: base_one_q <= cfg_data;
				REG_BASE_TWO: base_two_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sedh_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.fifo_full  (wr_st.full),
		.fifo_push  (fifo_push),
		.cmd        (wr_cmd)
	);

	sedh_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.wr_cmd (wr_cmd),
		.wr_st  (wr_st),
		.pop    (fifo_pop),
		.rd_cmd (rd_cmd),
		.rd_st  (rd_st)
	);

	sedh_back #(.MAX_LEN(MAX_LEN)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.base_one     (base_one_q),
		.base_two     (base_two_q),
		.cmd          (rd_cmd),
		.fifo_empty   (rd_st.empty),
		.fifo_pop     (fifo_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_st.push |-> !wr_st.full) else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_st.pop |-> !rd_st.empty) else $error("pop from empty queue");

	a_err_not_similar: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.range_error |-> !result.similar)
		else $error("range error reported as similar");

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives append and compare transfers into the substring hash compare core,
// predicts each compare answer from a local double-hash model at 64 bits,
// and checks the answers in order. Bases are reprogrammed between phases.
// ----------------------------------------------------------------------------
module testbench;
	import sedh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STR_MAX = 65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b1;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [BASE_W-1:0] cfg_data = '0;

	substring_equality_by_double_hash_core #(.MAX_LEN(STR_MAX)) u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// string model
	logic [63:0] pw1 [STR_MAX];
	logic [63:0] pw2 [STR_MAX];
	logic [63:0] ph1 [STR_MAX];
	logic [63:0] ph2 [STR_MAX];
	int unsigned str_len = 0;
	logic [63:0] mult_one = 64'd4;
	logic [63:0] mult_two = 64'd9;

	item_t   pending_items [$];
	result_t expected_answers [$];
	int errors = 0;
	int hold_cycles = 0;

	function automatic logic [63:0] seg_hash(ref logic [63:0] pre [STR_MAX],
			input int unsigned lo, input int unsigned hi);
		logic [63:0] h;
		h = pre[hi];
		if (lo != 0) h = h - pre[lo-1];
		return h;
	endfunction

	function automatic void predict_item(item_t it);
		int unsigned a, b, c, d, t;
		logic [63:0] digit;
		result_t r;
		if (it.req_type == 1'b0) begin
			if (it.start_new) str_len = 0;
			if (str_len >= STR_MAX) return;
			digit = {56'd0, it.char_byte} - 64'd96;
			if (str_len == 0) begin
				pw1[0] = 64'd1; pw2[0] = 64'd1; ph1[0] = digit; ph2[0] = digit;
			end else begin
				pw1[str_len] = pw1[str_len-1] * mult_one;
				pw2[str_len] = pw2[str_len-1] * mult_two;
				ph1[str_len] = ph1[str_len-1] + digit * pw1[str_len];
				ph2[str_len] = ph2[str_len-1] + digit * pw2[str_len];
			end
			str_len++;
			return;
		end
		a = 32'(it.first_start); b = 32'(it.first_end);
		c = 32'(it.second_start); d = 32'(it.second_end);
		r = '0;
		if (a == 0 || a > b || b > str_len || c == 0 || c > d || d > str_len) begin
			r.range_error = 1'b1;
		end else begin
			a--; b--; c--; d--;
			if (a > c) begin
				t = a; a = c; c = t;
				t = b; b = d; d = t;
			end
			if (b - a == d - c)
				r.similar = (seg_hash(ph1, a, b) * pw1[c-a] == seg_hash(ph1, c, d)) &&
					(seg_hash(ph2, a, b) * pw2[c-a] == seg_hash(ph2, c, d));
		end
		expected_answers.push_back(r);
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				predict_item(item);
				void'(pending_items.pop_front());
				send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
				if ($urandom_range(0, 2) == 0) send_gap = 0;
			end
			if (!(item_valid && item_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					item_valid <= 1'b1;
					item <= pending_items[0];
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int recv_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_answers.size() == 0) begin
					$error("unexpected result transfer");
					errors++;
				end else begin
					result_t e;
					e = expected_answers.pop_front();
					if (result.similar !== e.similar) begin
						$error("similar: expected %0b actual %0b", e.similar, result.similar);
						errors++;
					end
					if (result.range_error !== e.range_error) begin
						$error("range_error: expected %0b actual %0b",
							e.range_error, result.range_error);
						errors++;
					end
				end
				recv_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				result_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic push_append(bit fresh, logic [7:0] ch);
		item_t it;
		it = '0;
		it.req_type = 1'b0; it.start_new = fresh; it.char_byte = ch;
		it.first_start = 17'($urandom); it.first_end = 17'($urandom);
		it.second_start = 17'($urandom); it.second_end = 17'($urandom);
		pending_items.push_back(it);
	endtask

	task automatic push_compare(int unsigned s1, int unsigned e1,
			int unsigned s2, int unsigned e2);
		item_t it;
		it = '0;
		it.req_type = 1'b1; it.start_new = 1'($urandom); it.char_byte = 8'($urandom);
		it.first_start = 17'(s1); it.first_end = 17'(e1);
		it.second_start = 17'(s2); it.second_end = 17'(e2);
		pending_items.push_back(it);
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || item_valid || expected_answers.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_base(reg_index_t idx, logic [BASE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_BASE_ONE) mult_one = 64'(val); else mult_two = 64'(val);
	endtask

	// random phase on a short string; mostly well-formed equal-length compares
	task automatic random_phase(int n);
		int unsigned len, s1, s2, l;
		int shadow_len;
		shadow_len = 0;
		len = $urandom_range(4, 60);
		push_append(1'b1, 8'(($urandom_range(0, 9) == 0) ? $urandom :
			8'd97 + $urandom_range(0, 2)));
		shadow_len = 1;
		for (int k = 0; k < n; k++) begin
			if (shadow_len < len || $urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 40) == 0) begin
					push_append(1'b1, 8'($urandom)); shadow_len = 1;
				end else begin
					push_append(1'b0, 8'(($urandom_range(0, 9) == 0) ? $urandom :
						8'd97 + $urandom_range(0, 2)));
					shadow_len++;
				end
			end else if ($urandom_range(0, 5) == 0) begin
				push_compare($urandom_range(0, shadow_len + 2), $urandom_range(0, shadow_len + 2),
					$urandom_range(0, shadow_len + 2), $urandom_range(0, shadow_len + 2));
			end else begin
				l = $urandom_range(1, (shadow_len < 6) ? shadow_len : 6);
				s1 = $urandom_range(1, shadow_len - l + 1);
				s2 = $urandom_range(1, shadow_len - l + 1);
				if ($urandom_range(0, 3) == 0)
					push_compare(s1, s1 + l - 1 + $urandom_range(0, 1), s2, s2 + l - 1);
				else
					push_compare(s1, s1 + l - 1, s2, s2 + l - 1);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		push_compare(1, 1, 1, 1);
		push_append(1'b1, 8'd97);
		push_append(1'b0, 8'd98);
		push_append(1'b0, 8'd97);
		push_append(1'b0, 8'd98);
		push_append(1'b0, 8'd0);
		push_append(1'b0, 8'd255);
		push_compare(1, 2, 3, 4);
		push_compare(3, 4, 1, 2);
		push_compare(1, 2, 2, 3);
		push_compare(1, 3, 1, 2);
		push_compare(0, 1, 1, 1);
		push_compare(2, 1, 1, 1);
		push_compare(1, 7, 1, 1);
		push_compare(1, 1, 1, 6);
		push_compare(17'h1FFFF, 17'h1FFFF, 17'h10000, 17'h10000);
		push_compare(5, 6, 5, 6);
		push_append(1'b1, 8'd122);
		push_compare(1, 1, 1, 1);
		push_compare(1, 2, 1, 2);
		drain();

		// fill stage: receiver holds off while sender keeps offering
		hold_cycles = 400;
		random_phase(60);
		drain();

		write_base(REG_BASE_ONE, 16'd2);
		write_base(REG_BASE_TWO, 16'hFFFF);
		random_phase(300);
		drain();

		write_base(REG_BASE_ONE, 16'hFFFF);
		write_base(REG_BASE_TWO, 16'd2);
		random_phase(300);
		drain();
		write_base(REG_BASE_ONE, 16'd0);
		write_base(REG_BASE_TWO, 16'd1);
		random_phase(250);
		drain();

		write_base(REG_BASE_ONE, 16'd4);
		write_base(REG_BASE_TWO, 16'd9);
		random_phase(400);
		drain();
		write_base(REG_BASE_ONE, 16'($urandom));
		write_base(REG_BASE_TWO, 16'($urandom));
		random_phase(400);
		drain();

		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule
